/* design/htcf_pkg.sv */
package htcf_pkg;

  // Frame format constants.
  localparam int ID_DIGITS      = 3;
  localparam int MAX_DATA_BYTES = 8;

  // Widths of the result fields and of the digit counter.
  localparam int ID_W      = 12;
  localparam int LEN_W     = 4;
  localparam int PAYLOAD_W = 64;
  localparam int CNT_W     = 5;

  // Delimiter and digit characters.
  localparam logic [7:0] CHAR_OPEN  = 8'h5B;  // '['
  localparam logic [7:0] CHAR_COLON = 8'h3A;  // ':'
  localparam logic [7:0] CHAR_CLOSE = 8'h5D;  // ']'
  localparam logic [7:0] CHAR_NL    = 8'h0A;  // newline
  localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CHAR_UPA   = 8'h41;  // 'A'
  localparam logic [7:0] CHAR_LOWA  = 8'h61;  // 'a'

  // Classified character passed from the front end to the parser.
  typedef struct packed {
    logic [3:0] digit;
    logic       is_open;
    logic       is_colon;
    logic       is_close;
    logic       is_nl;
  } cls_t;

endpackage

/* design/hex_text_to_can_frame.sv */
// An accepted byte is written into the queue and popped from it into the parser registers;
// the frame closed by a newline is then loaded into the output register.
// Throughput: one byte per cycle, as each parser step pops one byte from the
// two-entry queue; a stalled output holds only a closing newline back, and the queue then fills and stalls the input.
// Reset: synchronous, active-low rst_n; the parser returns to hunting '[' with
// all accumulators cleared, and the queue and output register are emptied.
module hex_text_to_can_frame import htcf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // rx_byte[7:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,   // frame_id[11:0], data_length[15:12], payload[79:16]
  output logic        out_tuser    // skipped_garbage[0]
);

  logic                 q_wr_valid;
  logic                 q_wr_ready;
  cls_t                 q_wr_data;
  logic                 q_rd_valid;
  logic                 q_rd_pop;
  cls_t                 q_rd_data;
  logic [ID_W-1:0]      frame_id;
  logic [LEN_W-1:0]     data_length;
  logic [PAYLOAD_W-1:0] payload;
  logic                 skipped_garbage;

  htcf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .q_wr_valid (q_wr_valid),
    .q_wr_ready (q_wr_ready),
    .q_wr_data  (q_wr_data)
  );

  htcf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (q_wr_valid),
    .wr_ready (q_wr_ready),
    .wr_data  (q_wr_data),
    .rd_valid (q_rd_valid),
    .rd_pop   (q_rd_pop),
    .rd_data  (q_rd_data)
  );

  htcf_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_rd_valid),
    .q_pop           (q_rd_pop),
    .q_data          (q_rd_data),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .frame_id        (frame_id),
    .data_length     (data_length),
    .payload         (payload),
    .skipped_garbage (skipped_garbage)
  );

  assign out_tdata = {payload, data_length, frame_id};
  assign out_tuser = skipped_garbage;

endmodule

/* design/htcf_front.sv */
module htcf_front import htcf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // rx_byte[7:0]
  output logic       q_wr_valid,
  input  logic       q_wr_ready,
  output cls_t       q_wr_data
);

  logic [7:0] c;
  logic [7:0] off_num;
  logic [7:0] off_up;
  logic [7:0] off_low;

  assign c       = in_tdata;
  assign off_num = c - CHAR_ZERO;
  assign off_up  = c - CHAR_UPA;
  assign off_low = c - CHAR_LOWA;

  // Hex value of the character; anything that is not a hex digit reads as zero.
  always_comb begin
    q_wr_data.digit = 4'd0;
    if (c >= CHAR_ZERO && c <= CHAR_ZERO + 8'd9) begin
      q_wr_data.digit = off_num[3:0];
    end else if (c >= CHAR_UPA && c <= CHAR_UPA + 8'd5) begin
      q_wr_data.digit = off_up[3:0] + 4'd10;
    end else if (c >= CHAR_LOWA && c <= CHAR_LOWA + 8'd5) begin
      q_wr_data.digit = off_low[3:0] + 4'd10;
    end
    q_wr_data.is_open  = (c == CHAR_OPEN);
    q_wr_data.is_colon = (c == CHAR_COLON);
    q_wr_data.is_close = (c == CHAR_CLOSE);
    q_wr_data.is_nl    = (c == CHAR_NL);
  end

  // A transaction is taken whenever the queue has room.
  assign q_wr_valid = in_tvalid;
  assign in_tready  = q_wr_ready;

  // The queue never accepts a push while full, so a refused byte must stay offered.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && !in_tready) |-> !q_wr_ready)
    else $error("front accepted a byte the queue refused");

endmodule

/* design/htcf_queue.sv */
module htcf_queue import htcf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  cls_t wr_data,
  output logic rd_valid,
  input  logic rd_pop,
  output cls_t rd_data
);

  cls_t       mem_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic       push;
  logic       pop;

  assign wr_ready = (count_r != 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_pop && rd_valid;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) count_r != 2'd3)
    else $error("queue count out of range");
  assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd0 || count_r == 2'd2) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with count");
  assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd1) |-> (wr_ptr_r != rd_ptr_r))
    else $error("queue pointers disagree with count");

endmodule

/* design/htcf_back.sv */
module htcf_back import htcf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  cls_t                 q_data,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [ID_W-1:0]      frame_id,
  output logic [LEN_W-1:0]     data_length,
  output logic [PAYLOAD_W-1:0] payload,
  output logic                 skipped_garbage
);

  localparam logic [2:0] PH_OPEN   = 3'd0;
  localparam logic [2:0] PH_ID     = 3'd1;
  localparam logic [2:0] PH_COLON1 = 3'd2;
  localparam logic [2:0] PH_LEN    = 3'd3;
  localparam logic [2:0] PH_COLON2 = 3'd4;
  localparam logic [2:0] PH_DATA   = 3'd5;
  localparam logic [2:0] PH_CLOSE  = 3'd6;
  localparam logic [2:0] PH_NL     = 3'd7;

  localparam logic [CNT_W-1:0] ID_CNT  = CNT_W'(ID_DIGITS);
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_DATA_BYTES);

  logic [2:0]           phase_r, phase_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [ID_W-1:0]      id_r, id_nxt;
  logic [LEN_W-1:0]     len_r, len_nxt;
  logic [PAYLOAD_W-1:0] data_r, data_nxt;
  logic                 skip_r, skip_nxt;
  logic                 emit;
  logic                 step;
  logic [CNT_W-1:0]     cnt_inc;
  logic [3:0]           nib_idx;
  logic                 out_tvalid_r, out_tvalid_nxt;
  logic [ID_W-1:0]      out_id_r;
  logic [LEN_W-1:0]     out_len_r;
  logic [PAYLOAD_W-1:0] out_data_r;
  logic                 out_skip_r;

  // A newline in the last phase closes the frame and needs the output slot.
  assign emit    = (phase_r == PH_NL) && q_data.is_nl;
  assign q_pop   = q_valid && (!emit || !out_tvalid_r || out_tready);
  assign step    = q_pop;
  assign cnt_inc = cnt_r + 1'b1;
  assign nib_idx = {cnt_r[3:1], ~cnt_r[0]};

  // Parser state update for one classified character.
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    id_nxt    = id_r;
    len_nxt   = len_r;
    data_nxt  = data_r;
    skip_nxt  = skip_r;
    if (step) begin
      case (phase_r)
        PH_OPEN: begin
          if (q_data.is_open) begin
            phase_nxt = PH_ID;
            cnt_nxt   = '0;
          end else begin
            skip_nxt = 1'b1;
          end
        end
        PH_ID: begin
          id_nxt  = {id_r[ID_W-5:0], q_data.digit};
          cnt_nxt = cnt_inc;
          if (cnt_inc >= ID_CNT) begin
            phase_nxt = PH_COLON1;
            cnt_nxt   = '0;
          end
        end
        PH_COLON1: begin
          if (q_data.is_colon) begin
            phase_nxt = PH_LEN;
            cnt_nxt   = '0;
          end else begin
            skip_nxt = 1'b1;
          end
        end
        PH_LEN: begin
          len_nxt   = (q_data.digit > MAX_LEN) ? MAX_LEN : q_data.digit;
          phase_nxt = PH_COLON2;
        end
        PH_COLON2: begin
          if (q_data.is_colon) begin
            phase_nxt = (len_r == '0) ? PH_CLOSE : PH_DATA;
            cnt_nxt   = '0;
          end else begin
            skip_nxt = 1'b1;
          end
        end
        PH_DATA: begin
          // High nibble first within each byte.
          for (int i = 0; i < PAYLOAD_W / 4; i++) begin
            if (nib_idx == 4'(i)) begin
              data_nxt[4*i +: 4] = data_r[4*i +: 4] | q_data.digit;
            end
          end
          cnt_nxt = cnt_inc;
          if (cnt_inc >= {len_r, 1'b0}) begin
            phase_nxt = PH_CLOSE;
            cnt_nxt   = '0;
          end
        end
        PH_CLOSE: begin
          if (q_data.is_close) begin
            phase_nxt = PH_NL;
            cnt_nxt   = '0;
          end else begin
            skip_nxt = 1'b1;
          end
        end
        PH_NL: begin
          if (q_data.is_nl) begin
            phase_nxt = PH_OPEN;
            cnt_nxt   = '0;
            id_nxt    = '0;
            len_nxt   = '0;
            data_nxt  = '0;
            skip_nxt  = 1'b0;
          end else begin
            skip_nxt = 1'b1;
          end
        end
        default: begin
          phase_nxt = PH_OPEN;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_OPEN;
      cnt_r   <= '0;
      id_r    <= '0;
      len_r   <= '0;
      data_r  <= '0;
      skip_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      id_r    <= id_nxt;
      len_r   <= len_nxt;
      data_r  <= data_nxt;
      skip_r  <= skip_nxt;
    end
  end

  // Output register: loads the finished frame, clears when taken.
  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (step && emit) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      out_id_r   <= id_r;
      out_len_r  <= len_r;
      out_data_r <= data_r;
      out_skip_r <= skip_r;
    end
  end

  assign out_tvalid      = out_tvalid_r;
  assign frame_id        = out_id_r;
  assign data_length     = out_len_r;
  assign payload         = out_data_r;
  assign skipped_garbage = out_skip_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (len_r != '0 && cnt_r < {len_r, 1'b0}))
    else $error("data phase with no digits left");
  assert property (@(posedge clk) disable iff (!rst_n) len_r <= MAX_LEN)
    else $error("length above limit");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !out_tready) |-> !(q_pop && emit))
    else $error("frame overwrote an unread result");
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_OPEN) |-> (cnt_r == '0 && len_r == '0 && data_r == '0))
    else $error("stale frame state while hunting the opening bracket");

endmodule

/* bench/hex_text_to_can_frame_tb.sv */
module hex_text_to_can_frame_tb;
  import htcf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RX_BYTES      = 850;
  localparam int RESET_CYCLES  = 8;
  localparam int DRAIN_CYCLES  = 10;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int IDLE_PCT      = 21;
  localparam int QUIET_FROM    = 400;
  localparam int QUIET_TO      = 900;
  localparam int MAX_REPORTS   = 10;
  localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(MAX_DATA_BYTES);

  // Parser phases, in the order a well-formed frame walks through them.
  typedef enum logic [2:0] {
    P_OPEN, P_ID, P_COLON1, P_LEN, P_COLON2, P_DATA, P_CLOSE, P_NL
  } phase_t;

  typedef struct {
    logic [ID_W-1:0]      frame_id;
    logic [LEN_W-1:0]     data_length;
    logic [PAYLOAD_W-1:0] payload;
    logic                 skipped;
  } can_frame_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;    // rx_byte[7:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [79:0] out_tdata;   // frame_id[11:0], data_length[15:12], payload[79:16]
  logic        out_tuser;   // skipped_garbage[0]

  // Characters waiting to be sent and frames waiting to come out.
  logic [7:0] rx_q[$];
  logic [7:0] frame_bytes[$];
  can_frame_t frame_q[$];

  // Shadow copy of the parser state.
  phase_t               ph;
  logic [CNT_W-1:0]     dig_cnt;
  logic [ID_W-1:0]      id_acc;
  logic [LEN_W-1:0]     len_r;
  logic [PAYLOAD_W-1:0] data_acc;
  logic                 skip_r;

  int cyc;
  int errors;
  bit byte_presented;

  hex_text_to_can_frame dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Value of a character taken as a hex digit; anything else reads as zero.
  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return 4'(c - CHAR_ZERO);
    if (c >= "A" && c <= "F") return 4'(c - CHAR_UPA + 8'd10);
    if (c >= "a" && c <= "f") return 4'(c - CHAR_LOWA + 8'd10);
    return 4'd0;
  endfunction

  function automatic bit idle_roll();
    if (cyc >= QUIET_FROM && cyc < QUIET_TO) return 1'b0;
    return $urandom_range(99) < IDLE_PCT;
  endfunction

  task automatic clear_parser();
    ph       = P_OPEN;
    dig_cnt  = '0;
    id_acc   = '0;
    len_r    = '0;
    data_acc = '0;
    skip_r   = 1'b0;
  endtask

  // While a delimiter is awaited, anything else is skipped and flagged.
  task automatic wait_delim(input logic [7:0] c, input logic [7:0] want, input phase_t nxt);
    if (c == want) begin
      ph      = nxt;
      dig_cnt = '0;
    end else begin
      skip_r = 1'b1;
    end
  endtask

  // Advance the shadow parser by one character; a closing newline yields a frame.
  task automatic parse_char(input logic [7:0] c);
    logic [3:0] d;
    can_frame_t f;
    d = nibble_of(c);
    case (ph)
      P_OPEN: wait_delim(c, CHAR_OPEN, P_ID);
      P_ID: begin
        id_acc  = {id_acc[ID_W-5:0], d};
        dig_cnt = dig_cnt + 1'b1;
        if (dig_cnt >= ID_DIGITS) begin
          ph      = P_COLON1;
          dig_cnt = '0;
        end
      end
      P_COLON1: wait_delim(c, CHAR_COLON, P_LEN);
      P_LEN: begin
        len_r = (d > LEN_CAP) ? LEN_CAP : d;
        ph    = P_COLON2;
      end
      P_COLON2: begin
        if (len_r == 0) begin
          wait_delim(c, CHAR_COLON, P_CLOSE);
        end else begin
          wait_delim(c, CHAR_COLON, P_DATA);
        end
      end
      P_DATA: begin
        // High nibble of each byte arrives first.
        data_acc = data_acc |
                   (PAYLOAD_W'(d) << (8 * dig_cnt[3:1] + (dig_cnt[0] ? 0 : 4)));
        dig_cnt  = dig_cnt + 1'b1;
        if (dig_cnt >= 2 * len_r) begin
          ph      = P_CLOSE;
          dig_cnt = '0;
        end
      end
      P_CLOSE: wait_delim(c, CHAR_CLOSE, P_NL);
      default: begin
        if (c == CHAR_NL) begin
          f.frame_id    = id_acc;
          f.data_length = len_r;
          f.payload     = data_acc;
          f.skipped     = skip_r;
          frame_q.push_back(f);
          clear_parser();
        end else begin
          skip_r = 1'b1;
        end
      end
    endcase
  endtask

  function automatic logic [7:0] rand_hex_char();
    int k;
    k = $urandom_range(21);
    if (k < 10) return CHAR_ZERO + 8'(k);
    if (k < 16) return CHAR_UPA + 8'(k - 10);
    return CHAR_LOWA + 8'(k - 16);
  endfunction

  // A digit position mostly gets a hex character, now and then any byte at all.
  function automatic logic [7:0] rand_digit();
    if ($urandom_range(9) == 0) return 8'($urandom_range(255));
    return rand_hex_char();
  endfunction

  function automatic logic [7:0] rand_byte_except(input logic [7:0] c);
    logic [7:0] b;
    b = 8'($urandom_range(255));
    while (b == c) b = 8'($urandom_range(255));
    return b;
  endfunction

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) rx_q.push_back(s[i]);
  endtask

  // Stray characters in front of a delimiter, only on noisy frames.
  task automatic add_delim(input bit noisy, input logic [7:0] delim);
    if (noisy && $urandom_range(1)) begin
      repeat ($urandom_range(1, 3)) frame_bytes.push_back(rand_byte_except(delim));
    end
    frame_bytes.push_back(delim);
  endtask

  // Build one complete frame with random content into frame_bytes.
  task automatic build_frame(input bit noisy);
    logic [7:0] len_char;
    logic [3:0] n;
    frame_bytes.delete();
    add_delim(noisy, CHAR_OPEN);
    repeat (ID_DIGITS) frame_bytes.push_back(rand_digit());
    add_delim(noisy, CHAR_COLON);
    len_char = rand_digit();
    frame_bytes.push_back(len_char);
    add_delim(noisy, CHAR_COLON);
    n = nibble_of(len_char);
    if (n > LEN_CAP) n = LEN_CAP;
    repeat (2 * n) frame_bytes.push_back(rand_digit());
    add_delim(noisy, CHAR_CLOSE);
    add_delim(noisy, CHAR_NL);
  endtask

  // Input side: predict on every accepted character. Output side: check frames.
  always @(posedge clk) begin
    can_frame_t f;
    cyc <= cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("hex_text_to_can_frame_tb: done, errors");
      $finish;
    end
    if (rst_n && in_tvalid && in_tready) begin
      parse_char(in_tdata);
      byte_presented = 1'b0;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (frame_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("frame with none expected: id=%h len=%h data=%h skip=%b",
                   out_tdata[11:0], out_tdata[15:12], out_tdata[79:16], out_tuser);
      end else begin
        f = frame_q.pop_front();
        if (out_tdata[11:0] !== f.frame_id || out_tdata[15:12] !== f.data_length ||
            out_tdata[79:16] !== f.payload || out_tuser !== f.skipped) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("frame mismatch: exp id=%h len=%h data=%h skip=%b,",
                     f.frame_id, f.data_length, f.payload, f.skipped,
                     " got id=%h len=%h data=%h skip=%b",
                     out_tdata[11:0], out_tdata[15:12], out_tdata[79:16], out_tuser);
        end
      end
    end
  end

  // Driver: present the next character once the previous one is taken.
  always @(negedge clk) begin
    if (rst_n) begin
      out_tready <= !idle_roll();
      if (!byte_presented) begin
        if (rx_q.size() > 0 && !idle_roll()) begin
          in_tdata       <= rx_q.pop_front();
          in_tvalid      <= 1'b1;
          byte_presented = 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  initial begin
    int r;
    int cut;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    out_tready     = 1'b0;
    cyc            = 0;
    errors         = 0;
    byte_presented = 1'b0;
    clear_parser();

    // Junk before the bracket, a colon taken as an ID digit, a bracket
    // inside a frame, and a zero-length frame.
    rx_q.push_back(8'hFF);
    push_text("[a0:[:0:]\n");
    // Mixed-case hex, a NUL as a digit, one data byte, a stray before newline.
    push_text("[Ff");
    rx_q.push_back(8'h00);
    push_text(":1:9b]x\n");

    // Mostly well-formed frames, some truncated, some pure noise.
    while (rx_q.size() < RX_BYTES) begin
      r = $urandom_range(99);
      if (r < 70) begin
        build_frame($urandom_range(99) < 30);
        foreach (frame_bytes[i]) rx_q.push_back(frame_bytes[i]);
      end else if (r < 85) begin
        build_frame(1'b0);
        cut = $urandom_range(1, frame_bytes.size() - 1);
        for (int i = 0; i < cut; i++) rx_q.push_back(frame_bytes[i]);
      end else begin
        repeat ($urandom_range(1, 5)) rx_q.push_back(8'($urandom_range(255)));
      end
    end

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    while (rx_q.size() != 0 || byte_presented) @(posedge clk);
    while (frame_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("hex_text_to_can_frame_tb: done, clean");
    end else begin
      $display("hex_text_to_can_frame_tb: done, errors");
    end
    $finish;
  end

endmodule

/* files.f */
design/htcf_pkg.sv
design/htcf_front.sv
design/htcf_queue.sv
design/htcf_back.sv
design/hex_text_to_can_frame.sv
bench/hex_text_to_can_frame_tb.sv
